/* rtl/spi_ms_pkg.sv */
// Shared types, constants and helper functions for the SPI master shifter.
// Used by the interfaces, the next-state logic and the top level.
// No dependencies.
package spi_ms_pkg;

    localparam int unsigned DATA_W      = 16;
    localparam int unsigned DIV_W       = 8;
    localparam int unsigned WAIT_W      = 6;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned MAX_DIVIDER = 128;
    localparam int unsigned MIN_DIVIDER = 2;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SPI_MODE  = 2'd0,
        CFG_BIT_ORDER = 2'd1,
        CFG_CLK_DIV   = 2'd2
    } t_cfg_idx;

    // Segment phase within one bit, one-hot.
    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_DRIVE  = 4'b0010,
        PH_SAMPLE = 4'b0100,
        PH_TRAIL  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]       spi_mode;
        logic             bit_order;
        logic [DIV_W-1:0] clock_divider;
    } t_cfg;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_cnt;
        t_phase            phase;
        logic [CNT_W-1:0]  bit_cnt;
        logic [DATA_W-1:0] tx_shift;
        logic [DATA_W-1:0] rx_shift;
        logic              sck;
        logic              mosi;
        logic              busy;
        logic              op;
        logic              wide;
    } t_state;

    typedef struct packed {
        logic              sck_level;
        logic              mosi_level;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] rx_data;
    } t_result;

    // Reload value of the wait counter: clamped divider halved, minus one.
    function automatic logic [WAIT_W-1:0] seg_reload(input logic [DIV_W-1:0] div);
        logic [DIV_W-1:0] d;
        d = div;
        if (d > DIV_W'(MAX_DIVIDER)) begin
            d = DIV_W'(MAX_DIVIDER);
        end
        if (d < DIV_W'(MIN_DIVIDER)) begin
            d = DIV_W'(MIN_DIVIDER);
        end
        return WAIT_W'((d >> 1) - DIV_W'(1));
    endfunction

    // Data bit position driven and sampled for bit number cnt.
    function automatic logic [CNT_W-1:0] bit_pos(
        input logic             op,
        input logic             wide,
        input logic             order,
        input logic [CNT_W-1:0] cnt
    );
        logic [CNT_W-1:0] last;
        logic             byte_sel;
        last = wide ? CNT_W'(15) : CNT_W'(7);
        if (!op) begin
            return order ? cnt : CNT_W'(last - cnt);
        end
        byte_sel = wide ? (order ? cnt[3] : ~cnt[3]) : 1'b0;
        return {byte_sel, ~cnt[2:0]};
    endfunction

endpackage

/* rtl/spi_ms_in_if.sv */
// Input channel of the SPI master shifter: one tick word per handshake.
// Depends on spi_ms_pkg.
interface spi_ms_in_if
    import spi_ms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic              op;
    logic              wide;
    logic [DATA_W-1:0] tx_data;
    logic              miso_level;

    modport source (output valid, start_req, op, wide, tx_data, miso_level, input ready);
    modport sink   (input valid, start_req, op, wide, tx_data, miso_level, output ready);
endinterface

/* rtl/spi_ms_out_if.sv */
// Output channel of the SPI master shifter: one result word per handshake.
// Depends on spi_ms_pkg.
interface spi_ms_out_if
    import spi_ms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              sck_level;
    logic              mosi_level;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] rx_data;

    modport source (output valid, sck_level, mosi_level, busy_res, done_res, rx_data,
                    input ready);
    modport sink   (input valid, sck_level, mosi_level, busy_res, done_res, rx_data,
                    output ready);
endinterface

/* rtl/spi_ms_step.sv */
// Next-state logic of the SPI master shifter for one tick word.
// Depends on spi_ms_pkg.
module spi_ms_step
    import spi_ms_pkg::*;
(
    input  t_state            i_state,
    input  t_cfg              i_cfg,
    input  logic              i_start_req,
    input  logic              i_op,
    input  logic              i_wide,
    input  logic [DATA_W-1:0] i_tx_data,
    input  logic              i_miso_level,
    output t_state            o_state,
    output t_result           o_result
);

    logic [WAIT_W-1:0] reload;
    logic              cpha;
    logic              cpol;
    logic [DATA_W-1:0] start_tx;
    logic [CNT_W-1:0]  pos_cur;
    logic [CNT_W-1:0]  pos_next;
    logic [CNT_W-1:0]  pos_first;
    logic [CNT_W-1:0]  cnt_next;
    logic              is_last;

    assign reload    = seg_reload(i_cfg.clock_divider);
    assign cpha      = i_cfg.spi_mode[0];
    assign cpol      = i_cfg.spi_mode[1];
    assign start_tx  = i_wide ? i_tx_data : {8'h00, i_tx_data[7:0]};
    assign pos_first = bit_pos(i_op, i_wide, i_cfg.bit_order, '0);
    assign pos_cur   = bit_pos(i_state.op, i_state.wide, i_cfg.bit_order, i_state.bit_cnt);
    assign cnt_next  = i_state.bit_cnt + CNT_W'(1);
    assign pos_next  = bit_pos(i_state.op, i_state.wide, i_cfg.bit_order, cnt_next);
    assign is_last   = i_state.bit_cnt >= (i_state.wide ? CNT_W'(15) : CNT_W'(7));

    always_comb begin
        t_state n;
        logic   done;
        logic   end_bit;
        n       = i_state;
        done    = 1'b0;
        end_bit = 1'b0;

        if (!i_state.busy) begin
            n.sck = cpol;
            if (i_start_req) begin
                n.op       = i_op;
                n.wide     = i_wide;
                n.tx_shift = start_tx;
                n.rx_shift = '0;
                n.bit_cnt  = '0;
                n.busy     = 1'b1;
                if (!i_op && cpha) begin
                    n.phase = PH_LEAD;
                    n.sck   = ~cpol;
                end else begin
                    n.phase = PH_DRIVE;
                    n.mosi  = start_tx[pos_first];
                end
                n.wait_cnt = reload;
            end
        end else if (i_state.wait_cnt != '0) begin
            n.wait_cnt = i_state.wait_cnt - WAIT_W'(1);
        end else begin
            unique case (i_state.phase)
                PH_LEAD: begin
                    n.phase = PH_DRIVE;
                    n.mosi  = i_state.tx_shift[pos_cur];
                end
                PH_DRIVE: begin
                    n.phase = PH_SAMPLE;
                    if (i_state.op) begin
                        n.sck = 1'b1;
                    end else begin
                        n.sck              = ~i_state.sck;
                        n.rx_shift[pos_cur] = i_miso_level;
                    end
                end
                PH_SAMPLE: begin
                    if (i_state.op) begin
                        n.phase = PH_TRAIL;
                        n.sck   = 1'b0;
                    end else begin
                        end_bit = 1'b1;
                    end
                end
                default: begin
                    end_bit = 1'b1;
                end
            endcase

            if (end_bit) begin
                if (is_last) begin
                    n.busy  = 1'b0;
                    n.sck   = cpol;
                    n.phase = PH_LEAD;
                    done    = 1'b1;
                end else begin
                    n.bit_cnt = cnt_next;
                    if (!i_state.op && cpha) begin
                        n.phase = PH_LEAD;
                        n.sck   = ~i_state.sck;
                    end else begin
                        n.phase = PH_DRIVE;
                        if (!i_state.op) begin
                            n.sck = ~i_state.sck;
                        end
                        n.mosi = i_state.tx_shift[pos_next];
                    end
                end
            end

            if (!done) begin
                n.wait_cnt = reload;
            end
        end

        o_state             = n;
        o_result.sck_level  = n.sck;
        o_result.mosi_level = n.mosi;
        o_result.busy_res   = n.busy;
        o_result.done_res   = done;
        o_result.rx_data    = (done && !i_state.op) ? n.rx_shift : '0;
    end

endmodule

/* rtl/spi_master_shifter_unit.sv */
// SPI master shifter top level: configuration registers, tick state and result register.
// Depends on spi_ms_pkg, spi_ms_in_if, spi_ms_out_if and spi_ms_step.
// A tick's result word is registered and shown in the cycle after the tick is accepted.
// One tick word per cycle while o_out is ready; the result register frees when taken.
// Reset (synchronous, active low) clears the tick state, sets mode 0, MSB first and
// divider 128, and empties the result register.
module spi_master_shifter_unit
    import spi_ms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [DIV_W-1:0] i_cfg_data,
    spi_ms_in_if.sink        i_in,
    spi_ms_out_if.source     o_out
);

    // Configuration registers. A write while an operation runs acts from the next
    // segment on; the latched operation, width and data are kept.
    t_cfg    r_cfg;

    // Tick state, the shifter's whole memory between ticks.
    t_state  r_state;
    t_state  n_state;

    // Result register. It separates the two channels so that a new tick word can
    // be taken in the same cycle in which the previous result is delivered.
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;

    logic    in_accept;
    t_cfg_idx cfg_idx;

    assign cfg_idx   = t_cfg_idx'(i_cfg_idx);
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept = i_in.valid && i_in.ready;

    // All the work for one tick: wait counting, segment actions, pin levels.
    spi_ms_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_start_req  (i_in.start_req),
        .i_op         (i_in.op),
        .i_wide       (i_in.wide),
        .i_tx_data    (i_in.tx_data),
        .i_miso_level (i_in.miso_level),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    // Configuration writes. Index values beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spi_mode      <= 2'd0;
            r_cfg.bit_order     <= 1'b0;
            r_cfg.clock_divider <= DIV_W'(MAX_DIVIDER);
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                CFG_SPI_MODE:  r_cfg.spi_mode      <= i_cfg_data[1:0];
                CFG_BIT_ORDER: r_cfg.bit_order     <= i_cfg_data[0];
                CFG_CLK_DIV:   r_cfg.clock_divider <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tick state advances once per accepted word. While idle with no word accepted, a
    // polarity change moves the serial clock to its new idle level right away.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.wait_cnt <= '0;
            r_state.phase    <= PH_LEAD;
            r_state.bit_cnt  <= '0;
            r_state.tx_shift <= '0;
            r_state.rx_shift <= '0;
            r_state.sck      <= 1'b0;
            r_state.mosi     <= 1'b0;
            r_state.busy     <= 1'b0;
            r_state.op       <= 1'b0;
            r_state.wide     <= 1'b0;
        end else if (in_accept) begin
            r_state <= n_state;
        end else if (i_cfg_we && cfg_idx == CFG_SPI_MODE && !r_state.busy) begin
            r_state.sck <= i_cfg_data[1];
        end
    end

    // Result register: loaded on every accepted word, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sck_level  = r_out.sck_level;
    assign o_out.mosi_level = r_out.mosi_level;
    assign o_out.busy_res   = r_out.busy_res;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.rx_data    = r_out.rx_data;

endmodule
